// File: rtl/rtc_pkg.sv
// Shared types, constants and operand tables for the ray/triangle closest-hit block.
// Used by rtc_mac and ray_triangle_closest_hit; depends on nothing.
`timescale 1ns / 1ps
package rtc_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int ID_BITS_DEF    = 16;
    localparam int DIST_BITS      = 32;
    localparam int T_FRAC         = 16;
    localparam int CFG_IDX_BITS   = 3;
    localparam int DIR_Z_RESET    = 256;

    localparam logic [DIST_BITS-1:0] DIST_MAX = 32'h7FFF_FFFF;
    localparam logic [DIST_BITS-1:0] DIST_MIN = 32'h8000_0000;

    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIR_Z    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_DIST = 3'd6;

    // vectors held per triangle
    localparam logic [1:0] VEC_AB  = 2'd0;
    localparam logic [1:0] VEC_AC  = 2'd1;
    localparam logic [1:0] VEC_AO  = 2'd2;
    localparam logic [1:0] VEC_DIR = 2'd3;

    // determinants in issue order
    localparam logic [1:0] DET_D  = 2'd0;
    localparam logic [1:0] DET_NB = 2'd1;
    localparam logic [1:0] DET_NG = 2'd2;
    localparam logic [1:0] DET_NT = 2'd3;

    // multiply steps of one determinant: six minor products, three cofactor products
    localparam logic [3:0] STEP_U0   = 4'd6;
    localparam logic [3:0] STEP_U1   = 4'd7;
    localparam logic [3:0] STEP_LAST = 4'd8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DRAIN,
        S_NORM,
        S_BARY,
        S_DIV,
        S_DECIDE,
        S_OUT
    } rtc_state_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] det;
        logic [3:0] step;
    } mac_ctrl_t;

    typedef struct packed {
        logic [1:0] xcol;
        logic [1:0] xrow;
        logic [1:0] ycol;
        logic [1:0] yrow;
    } op_sel_t;

    // columns u, v, w are 0, 1, 2
    function automatic op_sel_t op_sel(input logic [3:0] step);
        op_sel_t s;
        s = '0;
        unique case (step)
            4'd0:    s = '{xcol: 2'd1, xrow: 2'd1, ycol: 2'd2, yrow: 2'd2};
            4'd1:    s = '{xcol: 2'd2, xrow: 2'd1, ycol: 2'd1, yrow: 2'd2};
            4'd2:    s = '{xcol: 2'd1, xrow: 2'd0, ycol: 2'd2, yrow: 2'd2};
            4'd3:    s = '{xcol: 2'd2, xrow: 2'd0, ycol: 2'd1, yrow: 2'd2};
            4'd4:    s = '{xcol: 2'd1, xrow: 2'd0, ycol: 2'd2, yrow: 2'd1};
            4'd5:    s = '{xcol: 2'd2, xrow: 2'd0, ycol: 2'd1, yrow: 2'd1};
            4'd6:    s = '{xcol: 2'd0, xrow: 2'd0, ycol: 2'd0, yrow: 2'd0};
            4'd7:    s = '{xcol: 2'd0, xrow: 2'd0, ycol: 2'd0, yrow: 2'd1};
            4'd8:    s = '{xcol: 2'd0, xrow: 2'd0, ycol: 2'd0, yrow: 2'd2};
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [1:0] det_vec(input logic [1:0] det, input logic [1:0] col);
        logic [1:0] v;
        v = VEC_DIR;
        unique case (col)
            2'd0:    v = (det == DET_NB) ? VEC_AO : VEC_AB;
            2'd1:    v = (det == DET_NG) ? VEC_AO : VEC_AC;
            2'd2:    v = (det == DET_NT) ? VEC_AO : VEC_DIR;
            default: v = VEC_DIR;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/rtc_mac.sv
// Shared multiplier with accumulator that forms one 3x3 determinant per nine steps.
// Depends on rtc_pkg.
`timescale 1ns / 1ps
module rtc_mac #(
    parameter int CW = rtc_pkg::COORD_BITS_DEF + 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rtc_pkg::mac_ctrl_t          issue,
    input  logic signed [CW-1:0]        x,
    input  logic signed [CW-1:0]        y,
    output logic                        det_done,
    output logic [1:0]                  det_idx,
    output logic signed [3*CW+2:0]      det_value
);
    import rtc_pkg::*;

    localparam int MW    = 2 * CW + 1;
    localparam int PW    = MW + CW;
    localparam int DET_W = 3 * CW + 3;

    logic signed [MW-1:0]    minor_reg [3];
    logic signed [PW-1:0]    prod_reg;
    logic signed [DET_W-1:0] acc_reg;
    mac_ctrl_t               ctrl_reg;
    logic signed [MW-1:0]    mul_a;
    logic signed [DET_W-1:0] prod_ext;
    logic signed [DET_W-1:0] diff;
    logic [3:0]              minor_sel;

    always_comb
    begin
        minor_sel = issue.step - STEP_U0;
        if (issue.step < STEP_U0)
        begin
            mul_a = {{(MW-CW){x[CW-1]}}, x};
        end
        else
        begin
            mul_a = minor_reg[minor_sel[1:0]];
        end
    end

    assign prod_ext  = {{(DET_W-PW){prod_reg[PW-1]}}, prod_reg};
    assign diff      = acc_reg - prod_ext;
    assign det_done  = ctrl_reg.valid && (ctrl_reg.step == STEP_LAST);
    assign det_idx   = ctrl_reg.det;
    assign det_value = acc_reg + prod_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * y;
        if (ctrl_reg.valid)
        begin
            if (ctrl_reg.step < STEP_U0)
            begin
                if (!ctrl_reg.step[0])
                begin
                    acc_reg <= prod_ext;
                end
                else
                begin
                    minor_reg[ctrl_reg.step[2:1]] <= diff[MW-1:0];
                end
            end
            else if (ctrl_reg.step == STEP_U0)
            begin
                acc_reg <= prod_ext;
            end
            else if (ctrl_reg.step == STEP_U1)
            begin
                acc_reg <= diff;
            end
        end
    end

endmodule

// File: rtl/rtc_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
module rtc_div #(
    parameter int NW = 70,
    parameter int DW = 54
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot
);
    localparam int CNT_W = $clog2(NW + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DW-1:0]    rem_reg;
    logic [NW-1:0]    num_reg;
    logic [DW-1:0]    den_reg;
    logic [DW:0]      rem_sh;
    logic [DW:0]      diff;
    logic             ge;

    assign rem_sh = {rem_reg, num_reg[NW-1]};
    assign diff   = rem_sh - {1'b0, den_reg};
    assign ge     = !diff[DW];
    assign done   = done_reg;
    assign quot   = num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            num_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
            num_reg <= {num_reg[NW-2:0], ge};
        end
    end

endmodule

// File: rtl/ray_triangle_closest_hit.sv
// Top level: configuration registers, sequencer, closest-hit state and result register.
// Depends on rtc_pkg, rtc_mac and rtc_div.
`timescale 1ns / 1ps
// Each triangle item is tested against the configured ray and the closest hit is tracked.
// One item is in flight at a time: s_tready is high only while idle. The four
// determinants go through one shared multiplier, 36 products issued one per cycle,
// and t comes from a bit-serial divider of 3*(COORD_BITS+1)+3+16 steps (70 at the
// default widths). An item goes through the multiply, drain, normalise, barycentric,
// divide and decide states to its result, skipping the last two when the determinant
// is zero or the point lies outside the triangle. The result then waits on m_tready.
module ray_triangle_closest_hit #(
    parameter int COORD_BITS = rtc_pkg::COORD_BITS_DEF,
    parameter int ID_BITS    = rtc_pkg::ID_BITS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         cfg_we,
    input  logic [rtc_pkg::CFG_IDX_BITS-1:0]             cfg_index,
    input  logic [rtc_pkg::DIST_BITS-1:0]                cfg_data,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x .. vertex_c_z, triangle_id
    input  logic [((9*COORD_BITS+ID_BITS+7)/8)*8-1:0]    s_tdata,
    // new_ray
    input  logic                                         s_tuser,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // accepted, any_hit, closest_distance, closest_id
    output logic [((2+rtc_pkg::DIST_BITS+ID_BITS+7)/8)*8-1:0] m_tdata
);
    import rtc_pkg::*;

    localparam int CW    = COORD_BITS + 1;
    localparam int DET_W = 3 * CW + 3;
    localparam int NUM_W = DET_W + T_FRAC;
    localparam int OUT_W = ((2+DIST_BITS+ID_BITS+7)/8)*8;
    localparam int OUT_PAD = OUT_W - (2 + DIST_BITS + ID_BITS);

    rtc_state_t state_reg, state_next;

    logic signed [COORD_BITS-1:0] org_reg [3];
    logic signed [COORD_BITS-1:0] dir_reg [3];
    logic signed [DIST_BITS-1:0]  min_reg;

    logic signed [CW-1:0]    vec_reg [4][3];
    logic signed [DET_W-1:0] det_reg [4];
    logic signed [DET_W-1:0] dd_reg, nb_reg, ng_reg, nt_reg;
    logic [ID_BITS-1:0]      id_reg;
    logic [1:0]              det_cnt_reg;
    logic [3:0]              step_reg;

    logic signed [DIST_BITS-1:0] best_dist_reg;
    logic [ID_BITS-1:0]          best_id_reg;
    logic                        hit_reg;
    logic                        accepted_reg;

    mac_ctrl_t               issue;
    op_sel_t                 sel;
    logic signed [CW-1:0]    op_x, op_y;
    logic                    det_done;
    logic [1:0]              det_idx;
    logic signed [DET_W-1:0] det_value;

    logic                    div_start;
    logic                    div_done;
    logic [NUM_W-1:0]        div_q;
    logic [NUM_W-1:0]        div_num;
    logic signed [DET_W-1:0] nt_abs;
    logic signed [DET_W:0]   bary_sum;
    logic                    bary_ok;
    logic                    ovf;
    logic signed [DIST_BITS-1:0] t_val;
    logic                    in_acc;

    assign in_acc = s_tvalid && s_tready;

    assign sel  = op_sel(step_reg);
    assign op_x = vec_reg[det_vec(det_cnt_reg, sel.xcol)][sel.xrow];
    assign op_y = vec_reg[det_vec(det_cnt_reg, sel.ycol)][sel.yrow];

    rtc_mac #(
        .CW (CW)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .x         (op_x),
        .y         (op_y),
        .det_done  (det_done),
        .det_idx   (det_idx),
        .det_value (det_value)
    );

    assign nt_abs  = nt_reg[DET_W-1] ? -nt_reg : nt_reg;
    assign div_num = {nt_abs, {T_FRAC{1'b0}}};

    rtc_div #(
        .NW (NUM_W),
        .DW (DET_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (dd_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    assign bary_sum = {nb_reg[DET_W-1], nb_reg} + {ng_reg[DET_W-1], ng_reg};
    assign bary_ok  = (dd_reg != '0) && !nb_reg[DET_W-1] && (nb_reg != '0)
                      && !ng_reg[DET_W-1] && (ng_reg != '0)
                      && (bary_sum < {dd_reg[DET_W-1], dd_reg});

    always_comb
    begin
        ovf = |div_q[NUM_W-1:DIST_BITS];
        if (nt_reg[DET_W-1])
        begin
            if (ovf || (div_q[DIST_BITS-1] && (div_q[DIST_BITS-2:0] != '0)))
            begin
                t_val = DIST_MIN;
            end
            else
            begin
                t_val = -div_q[DIST_BITS-1:0];
            end
        end
        else
        begin
            if (ovf || div_q[DIST_BITS-1])
            begin
                t_val = DIST_MAX;
            end
            else
            begin
                t_val = div_q[DIST_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        issue      = '0;
        div_start  = 1'b0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                issue = '{valid: 1'b1, det: det_cnt_reg, step: step_reg};
                if (det_cnt_reg == DET_NT && step_reg == STEP_LAST)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_NORM;
            end
            S_NORM:
            begin
                state_next = S_BARY;
            end
            S_BARY:
            begin
                if (bary_ok)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            det_cnt_reg <= '0;
            step_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
            begin
                det_cnt_reg <= DET_D;
                step_reg    <= '0;
            end
            else if (state_reg == S_MUL)
            begin
                if (step_reg == STEP_LAST)
                begin
                    step_reg    <= '0;
                    det_cnt_reg <= det_cnt_reg + 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            dir_reg[0] <= '0;
            dir_reg[1] <= '0;
            dir_reg[2] <= COORD_BITS'(DIR_Z_RESET);
            min_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORIGIN_X: org_reg[0] <= cfg_data[COORD_BITS-1:0];
                REG_ORIGIN_Y: org_reg[1] <= cfg_data[COORD_BITS-1:0];
                REG_ORIGIN_Z: org_reg[2] <= cfg_data[COORD_BITS-1:0];
                REG_DIR_X:    dir_reg[0] <= cfg_data[COORD_BITS-1:0];
                REG_DIR_Y:    dir_reg[1] <= cfg_data[COORD_BITS-1:0];
                REG_DIR_Z:    dir_reg[2] <= cfg_data[COORD_BITS-1:0];
                REG_MIN_DIST: min_reg    <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_dist_reg <= DIST_MAX;
            best_id_reg   <= '0;
            hit_reg       <= 1'b0;
            accepted_reg  <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                accepted_reg <= 1'b0;
                if (s_tuser)
                begin
                    best_dist_reg <= DIST_MAX;
                    best_id_reg   <= '0;
                    hit_reg       <= 1'b0;
                end
            end
            else if (state_reg == S_DECIDE)
            begin
                if (t_val > min_reg && t_val < best_dist_reg)
                begin
                    best_dist_reg <= t_val;
                    best_id_reg   <= id_reg;
                    hit_reg       <= 1'b1;
                    accepted_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            for (int k = 0; k < 3; k++)
            begin
                logic signed [COORD_BITS-1:0] va, vb, vc;
                va = s_tdata[k*COORD_BITS +: COORD_BITS];
                vb = s_tdata[(3+k)*COORD_BITS +: COORD_BITS];
                vc = s_tdata[(6+k)*COORD_BITS +: COORD_BITS];
                vec_reg[VEC_AB][k]  <= {va[COORD_BITS-1], va} - {vb[COORD_BITS-1], vb};
                vec_reg[VEC_AC][k]  <= {va[COORD_BITS-1], va} - {vc[COORD_BITS-1], vc};
                vec_reg[VEC_AO][k]  <= {va[COORD_BITS-1], va}
                                       - {org_reg[k][COORD_BITS-1], org_reg[k]};
                vec_reg[VEC_DIR][k] <= {dir_reg[k][COORD_BITS-1], dir_reg[k]};
            end
            id_reg <= s_tdata[9*COORD_BITS +: ID_BITS];
        end
        if (det_done)
        begin
            det_reg[det_idx] <= det_value;
        end
        if (state_reg == S_NORM)
        begin
            if (det_reg[DET_D][DET_W-1])
            begin
                dd_reg <= -det_reg[DET_D];
                nb_reg <= -det_reg[DET_NB];
                ng_reg <= -det_reg[DET_NG];
                nt_reg <= -det_reg[DET_NT];
            end
            else
            begin
                dd_reg <= det_reg[DET_D];
                nb_reg <= det_reg[DET_NB];
                ng_reg <= det_reg[DET_NG];
                nt_reg <= det_reg[DET_NT];
            end
        end
    end

    assign m_tdata = {{OUT_PAD{1'b0}}, best_id_reg, best_dist_reg, hit_reg, accepted_reg};

endmodule

// File: rtl/rtc_checker.sv
// Port-level checks for ray_triangle_closest_hit, attached by bind.
// Depends on the top level's port names and its OUT_W localparam only.
`timescale 1ns / 1ps
module rtc_checker #(
    parameter int OUT_W = 56
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item dropped or changed while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready did not drop after an accepted item");

    a_accept_implies_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tdata[0] || m_tdata[1]))
        else $error("accepted flag without any_hit");

endmodule

bind ray_triangle_closest_hit rtc_checker #(.OUT_W(OUT_W)) u_rtc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
